// ===== rtl/lidar_scan_row_segmenter_macros.svh =====
// ---------------------------------------------------------------------------
// lidar scan row segmenter assertion macros
// concurrent assertion helpers used by the checker file lsrs_chk
// ---------------------------------------------------------------------------
`ifndef LIDAR_SCAN_ROW_SEGMENTER_MACROS_SVH
`define LIDAR_SCAN_ROW_SEGMENTER_MACROS_SVH

// checked only outside reset
`define LSRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LSRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lsrs_pkg.sv =====
// ---------------------------------------------------------------------------
// lsrs_pkg
// shared types, codes and helper functions of the lidar scan row segmenter
// ---------------------------------------------------------------------------
package lsrs_pkg;

    localparam int TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1000;

    localparam int CHG_W = 3;
    localparam logic [CHG_W-1:0] CHG_CLOSE = 3'd4;

    typedef logic [2:0] t_quad;
    localparam t_quad QUAD_XP_YNN = 3'd0;
    localparam t_quad QUAD_XNN_YN = 3'd1;
    localparam t_quad QUAD_XN_YNP = 3'd2;
    localparam t_quad QUAD_XNP_YP = 3'd3;
    localparam t_quad QUAD_ORIGIN = 3'd4;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_FINITE  = 2'd0;
    localparam t_kind KIND_POS_INF = 2'd1;
    localparam t_kind KIND_NEG_INF = 2'd2;
    localparam t_kind KIND_UNDEF   = 2'd3;

    function automatic t_quad f_quadrant(input logic x_neg, input logic x_zero,
                                         input logic y_neg, input logic y_zero);
        logic x_pos;
        logic y_pos;
        t_quad q;
        x_pos = !x_neg && !x_zero;
        y_pos = !y_neg && !y_zero;
        if (x_pos && !y_neg) begin
            q = QUAD_XP_YNN;
        end else if (!x_neg && y_neg) begin
            q = QUAD_XNN_YN;
        end else if (x_neg && !y_pos) begin
            q = QUAD_XN_YNP;
        end else if (!x_pos && y_pos) begin
            q = QUAD_XNP_YP;
        end else begin
            q = QUAD_ORIGIN;
        end
        return q;
    endfunction

    function automatic t_kind f_ratio_kind(input logic x_zero, input logic y_neg,
                                           input logic y_zero);
        t_kind k;
        if (!x_zero) begin
            k = KIND_FINITE;
        end else if (y_zero) begin
            k = KIND_UNDEF;
        end else if (y_neg) begin
            k = KIND_NEG_INF;
        end else begin
            k = KIND_POS_INF;
        end
        return k;
    endfunction

endpackage

// ===== rtl/lsrs_ratio.sv =====
// ---------------------------------------------------------------------------
// lsrs_ratio
// exact azimuth test y/x <= ref_y/ref_x by cross multiplication
// ---------------------------------------------------------------------------
module lsrs_ratio #(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  lsrs_pkg::t_kind              i_ref_kind,
    input  logic signed [COORD_BITS:0]   i_ref_c,
    input  logic signed [COORD_BITS:0]   i_ref_d,
    output logic                         o_at_or_below
);

    localparam int AW = COORD_BITS + 1;

    logic               x_neg;
    logic               x_zero;
    logic               y_neg;
    logic               y_zero;
    lsrs_pkg::t_kind    kind;
    logic signed [AW-1:0]   ext_x;
    logic signed [AW-1:0]   ext_y;
    logic signed [AW-1:0]   num_a;
    logic signed [AW-1:0]   den_b;
    logic signed [2*AW-1:0] prod_ad;
    logic signed [2*AW-1:0] prod_cb;

    assign x_neg  = i_x[COORD_BITS-1];
    assign x_zero = (i_x == '0);
    assign y_neg  = i_y[COORD_BITS-1];
    assign y_zero = (i_y == '0);
    assign kind   = lsrs_pkg::f_ratio_kind(x_zero, y_neg, y_zero);

    assign ext_x = AW'(i_x);
    assign ext_y = AW'(i_y);

    // make the denominator positive, sign moves to the numerator
    assign num_a = x_neg ? -ext_y : ext_y;
    assign den_b = x_neg ? -ext_x : ext_x;

    assign prod_ad = num_a * i_ref_d;
    assign prod_cb = i_ref_c * den_b;

    always_comb begin
        if (kind == lsrs_pkg::KIND_UNDEF || i_ref_kind == lsrs_pkg::KIND_UNDEF) begin
            o_at_or_below = 1'b0;
        end else if (kind == lsrs_pkg::KIND_NEG_INF || i_ref_kind == lsrs_pkg::KIND_POS_INF) begin
            o_at_or_below = 1'b1;
        end else if (kind == lsrs_pkg::KIND_POS_INF || i_ref_kind == lsrs_pkg::KIND_NEG_INF) begin
            o_at_or_below = 1'b0;
        end else begin
            o_at_or_below = (prod_ad <= prod_cb);
        end
    end

endmodule

// ===== rtl/lsrs_rowchk.sv =====
// ---------------------------------------------------------------------------
// lsrs_rowchk
// width check of a closing row against the mean of the kept rows
// ---------------------------------------------------------------------------
module lsrs_rowchk #(
    parameter int MAX_COLUMNS = 32768,
    parameter int MAX_ROWS    = 128
) (
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]          i_width,
    input  logic [$clog2(MAX_ROWS+1)-1:0]             i_row_cnt,
    input  logic [$clog2(MAX_ROWS*MAX_COLUMNS+1)-1:0] i_sum,
    input  logic [lsrs_pkg::TOL_W-1:0]                i_tol,
    output logic                                      o_keep
);

    localparam int WID_W  = $clog2(MAX_COLUMNS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int SUM_W  = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
    localparam int PW_W   = WID_W + RCNT_W;
    localparam int LIM_W  = lsrs_pkg::TOL_W + RCNT_W;
    localparam int MAX_AB = (PW_W > LIM_W) ? PW_W : LIM_W;
    localparam int CMP_W  = ((MAX_AB > SUM_W) ? MAX_AB : SUM_W) + 1;
    localparam logic [RCNT_W-1:0] ROWS_LIMIT = RCNT_W'(MAX_ROWS);

    logic [PW_W-1:0]         prod_w;
    logic [LIM_W-1:0]        lim;
    logic signed [CMP_W-1:0] diff;
    logic [CMP_W-1:0]        mag;

    // |w*n - sum| < tol*n is |w - mean| < tol without a divide
    assign prod_w = i_width * i_row_cnt;
    assign lim    = i_tol * i_row_cnt;
    assign diff   = $signed(CMP_W'(prod_w)) - $signed(CMP_W'(i_sum));
    assign mag    = (diff < 0) ? CMP_W'(-diff) : CMP_W'(diff);

    always_comb begin
        if (i_row_cnt >= ROWS_LIMIT) begin
            o_keep = 1'b0;
        end else if (i_row_cnt == '0) begin
            // first row is compared with itself
            o_keep = (i_tol != '0);
        end else begin
            o_keep = (mag < CMP_W'(lim));
        end
    end

endmodule

// ===== rtl/lidar_scan_row_segmenter.sv =====
// ---------------------------------------------------------------------------
// lidar_scan_row_segmenter
// assigns each lidar point a row and column of an ordered grid
// ---------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall with i_first_point, i_pos_x, i_pos_y;
// a request moves at an edge with valid high and stall low
// output channel: o_out_valid / i_out_stall with column, row, row flags,
// rows_kept, grid_width and index_overflow, one result per point
// configuration: i_cfg_we / i_cfg_wdata write width_tolerance; the user must
// write it only while idle, not enforced by the block; a point passes the
// input register, then the result register; throughput: one point per cycle
// unless the receiver stalls; each row state update is combinational, through
// the azimuth cross multiply and the width check multiply; the input register
// keeps taking points while a result waits, and o_in_stall rises only when
// both the input and result registers are full and the receiver stalls; a
// stalled result holds its value; reset clears both registers and all row
// state, width_tolerance returns to 1000 and the reference becomes the
// origin, so no row closes until a point with i_first_point arrives
// ---------------------------------------------------------------------------
module lidar_scan_row_segmenter #(
    parameter int MAX_COLUMNS = 32768,
    parameter int MAX_ROWS    = 128,
    parameter int COORD_BITS  = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [lsrs_pkg::TOL_W-1:0]            i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_first_point,
    input  logic signed [COORD_BITS-1:0]          i_pos_x,
    input  logic signed [COORD_BITS-1:0]          i_pos_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [$clog2(MAX_COLUMNS)-1:0]        o_column,
    output logic [$clog2(MAX_ROWS)-1:0]           o_row,
    output logic                                  o_row_closed,
    output logic                                  o_row_kept,
    output logic [$clog2(MAX_ROWS+1)-1:0]         o_rows_kept,
    output logic [$clog2(MAX_COLUMNS+1)-1:0]      o_grid_width,
    output logic                                  o_index_overflow
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int WID_W  = $clog2(MAX_COLUMNS + 1);
    localparam int SUM_W  = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
    localparam int AW     = COORD_BITS + 1;
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(MAX_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(MAX_ROWS - 1);
    localparam logic [RCNT_W-1:0] ROWS_LIMIT = RCNT_W'(MAX_ROWS);
    localparam logic [WID_W-1:0]  COLS_MAX   = WID_W'(MAX_COLUMNS);

    // configuration
    logic [lsrs_pkg::TOL_W-1:0] r_tol;

    // input register
    logic                         r_s1_valid;
    logic                         r_s1_first;
    logic signed [COORD_BITS-1:0] r_s1_x;
    logic signed [COORD_BITS-1:0] r_s1_y;

    // row state
    lsrs_pkg::t_kind              r_ref_kind, n_ref_kind;
    logic signed [AW-1:0]         r_ref_c, n_ref_c;
    logic signed [AW-1:0]         r_ref_d, n_ref_d;
    lsrs_pkg::t_quad              r_last_quad, n_last_quad;
    logic [lsrs_pkg::CHG_W-1:0]   r_chg_cnt, n_chg_cnt;
    logic [COL_W-1:0]             r_col_cnt, n_col_cnt;
    logic                         r_col_full, n_col_full;
    logic [RCNT_W-1:0]            r_row_cnt, n_row_cnt;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic [WID_W-1:0]             r_narrow, n_narrow;

    // result register
    logic                         r_out_valid;
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_row, n_row;
    logic                         r_closed, n_closed;
    logic                         r_kept, n_kept;
    logic [RCNT_W-1:0]            r_rows_kept;
    logic [WID_W-1:0]             r_gw, n_gw;
    logic                         r_ovf, n_ovf;

    logic                         advance;
    logic                         x_neg;
    logic                         x_zero;
    logic                         y_neg;
    logic                         y_zero;
    lsrs_pkg::t_quad              quad;
    logic                         ratio_ok;
    logic                         keep_cand;
    logic [WID_W-1:0]             width;
    logic [lsrs_pkg::CHG_W-1:0]   chg_pre;
    logic [COL_W-1:0]             base_col;
    logic                         base_full;
    logic [WID_W:0]               gw_full;
    logic signed [AW-1:0]         ext_x;
    logic signed [AW-1:0]         ext_y;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;

    assign x_neg  = r_s1_x[COORD_BITS-1];
    assign x_zero = (r_s1_x == '0);
    assign y_neg  = r_s1_y[COORD_BITS-1];
    assign y_zero = (r_s1_y == '0);
    assign quad   = lsrs_pkg::f_quadrant(x_neg, x_zero, y_neg, y_zero);
    assign ext_x  = AW'(r_s1_x);
    assign ext_y  = AW'(r_s1_y);

    // a saturated row counts one column past the last index
    assign width = WID_W'(r_col_cnt) + WID_W'(r_col_full);

    lsrs_ratio #(
        .COORD_BITS (COORD_BITS)
    ) u_ratio (
        .i_x           (r_s1_x),
        .i_y           (r_s1_y),
        .i_ref_kind    (r_ref_kind),
        .i_ref_c       (r_ref_c),
        .i_ref_d       (r_ref_d),
        .o_at_or_below (ratio_ok)
    );

    lsrs_rowchk #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_rowchk (
        .i_width   (width),
        .i_row_cnt (r_row_cnt),
        .i_sum     (r_sum),
        .i_tol     (r_tol),
        .o_keep    (keep_cand)
    );

    always_comb begin
        n_ref_kind  = r_ref_kind;
        n_ref_c     = r_ref_c;
        n_ref_d     = r_ref_d;
        n_last_quad = quad;
        n_chg_cnt   = r_chg_cnt;
        n_row_cnt   = r_row_cnt;
        n_sum       = r_sum;
        n_narrow    = r_narrow;
        n_closed    = 1'b0;
        n_kept      = 1'b0;
        base_col    = r_col_cnt;
        base_full   = r_col_full;
        chg_pre     = r_chg_cnt;

        if (r_s1_first) begin
            // capture the reference with its denominator made positive
            n_ref_kind = lsrs_pkg::f_ratio_kind(x_zero, y_neg, y_zero);
            n_ref_c    = x_neg ? -ext_y : ext_y;
            n_ref_d    = x_neg ? -ext_x : ext_x;
            n_chg_cnt  = '0;
            n_row_cnt  = '0;
            n_sum      = '0;
            n_narrow   = COLS_MAX;
            base_col   = '0;
            base_full  = 1'b0;
        end else begin
            if (quad != r_last_quad && r_chg_cnt < lsrs_pkg::CHG_CLOSE) begin
                chg_pre = r_chg_cnt + 1'b1;
            end
            n_chg_cnt = chg_pre;
            if (chg_pre >= lsrs_pkg::CHG_CLOSE && ratio_ok) begin
                n_closed  = 1'b1;
                n_chg_cnt = '0;
                n_kept    = keep_cand;
                base_col  = '0;
                base_full = 1'b0;
                if (keep_cand) begin
                    if (width < r_narrow) begin
                        n_narrow = width;
                    end
                    n_sum     = r_sum + SUM_W'(width);
                    n_row_cnt = r_row_cnt + 1'b1;
                end
            end
        end

        n_col      = base_col;
        n_ovf      = base_full;
        n_col_cnt  = base_col;
        n_col_full = base_full;
        if (base_col < COL_LAST) begin
            n_col_cnt = base_col + 1'b1;
        end else begin
            n_col_full = 1'b1;
        end

        if (n_row_cnt >= ROWS_LIMIT) begin
            n_row = ROW_LAST;
            n_ovf = 1'b1;
        end else begin
            n_row = n_row_cnt[ROW_W-1:0];
        end

        gw_full = (WID_W + 1)'(n_narrow) + 1'b1;
        if (n_row_cnt == '0) begin
            n_gw = '0;
        end else if (gw_full > (WID_W + 1)'(COLS_MAX)) begin
            n_gw = COLS_MAX;
        end else begin
            n_gw = gw_full[WID_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= lsrs_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_first <= i_first_point;
            r_s1_x     <= i_pos_x;
            r_s1_y     <= i_pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_kind  <= lsrs_pkg::KIND_UNDEF;
            r_ref_c     <= '0;
            r_ref_d     <= '0;
            r_last_quad <= lsrs_pkg::QUAD_XP_YNN;
            r_chg_cnt   <= '0;
            r_col_cnt   <= '0;
            r_col_full  <= 1'b0;
            r_row_cnt   <= '0;
            r_sum       <= '0;
            r_narrow    <= COLS_MAX;
        end else if (advance) begin
            r_ref_kind  <= n_ref_kind;
            r_ref_c     <= n_ref_c;
            r_ref_d     <= n_ref_d;
            r_last_quad <= n_last_quad;
            r_chg_cnt   <= n_chg_cnt;
            r_col_cnt   <= n_col_cnt;
            r_col_full  <= n_col_full;
            r_row_cnt   <= n_row_cnt;
            r_sum       <= n_sum;
            r_narrow    <= n_narrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_closed    <= n_closed;
            r_kept      <= n_kept;
            r_rows_kept <= n_row_cnt;
            r_gw        <= n_gw;
            r_ovf       <= n_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_column         = r_col;
    assign o_row            = r_row;
    assign o_row_closed     = r_closed;
    assign o_row_kept       = r_kept;
    assign o_rows_kept      = r_rows_kept;
    assign o_grid_width     = r_gw;
    assign o_index_overflow = r_ovf;

endmodule

// ===== rtl/lsrs_chk.sv =====
// ---------------------------------------------------------------------------
// lsrs_chk
// port level checks of the lidar scan row segmenter, bound to the top level
// ---------------------------------------------------------------------------
`include "lidar_scan_row_segmenter_macros.svh"

module lsrs_chk #(
    parameter int MAX_COLUMNS = 32768,
    parameter int MAX_ROWS    = 128
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [$clog2(MAX_COLUMNS)-1:0]   o_column,
    input logic [$clog2(MAX_ROWS)-1:0]      o_row,
    input logic                             o_row_closed,
    input logic                             o_row_kept,
    input logic [$clog2(MAX_ROWS+1)-1:0]    o_rows_kept,
    input logic [$clog2(MAX_COLUMNS+1)-1:0] o_grid_width
);

    // a stalled result stays offered
    `LSRS_ASSERT(a_valid_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "stalled result dropped")

    // a stalled result keeps its payload
    `LSRS_ASSERT(a_payload_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> ($stable(o_column) && $stable(o_row) && $stable(o_grid_width)), "stalled result changed")

    // only a closed row can be kept
    `LSRS_ASSERT(a_kept_closed, i_clk, i_rst_n, (o_out_valid && o_row_kept) |-> o_row_closed, "row kept without a close")

    // an empty grid has no width
    `LSRS_ASSERT(a_empty_grid, i_clk, i_rst_n, (o_out_valid && o_rows_kept == '0) |-> (o_grid_width == '0), "grid width without kept rows")

    // reset empties the result register
    `LSRS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind lidar_scan_row_segmenter lsrs_chk #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
) u_lsrs_chk (.*);
